// ===== rtl/ili_pkg.sv =====
// ----------------------------------------------------------------------------
// ili_pkg
// Shared types and constants for the indexed list with insert and delete.
// ----------------------------------------------------------------------------
`default_nettype none

package ili_pkg;

    // operation codes carried in the mode field
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    // width that holds any list index or length over the parameter range (up to 64)
    localparam int IDX_W = 7;

    typedef struct packed {
        logic [1:0]         mode;
        logic [4:0]         position;
        logic signed [31:0] value_in;
    } req_t;

    typedef struct packed {
        logic               ok;
        logic [4:0]         count_after;
        logic signed [31:0] read_value;
    } rsp_t;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic        shift_ins;
        logic        shift_del;
        logic [4:0]  position;
        logic [31:0] value;
    } cell_ctrl_t;

endpackage : ili_pkg

`default_nettype wire

// ===== rtl/ili_cell.sv =====
// ----------------------------------------------------------------------------
// ili_cell
// One list entry; loads a new value or takes a neighbor's entry on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module ili_cell
    import ili_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  wire logic        clk,
    input  wire cell_ctrl_t  ctrl,
    input  wire logic [31:0] prev_data,
    input  wire logic [31:0] next_data,
    output logic [31:0]      data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [31:0]      data_reg;
    logic [31:0]      data_next;
    logic [IDX_W-1:0] pos_ext;

    assign pos_ext = IDX_W'(ctrl.position);

    always_comb
    begin
        data_next = data_reg;
        priority if (ctrl.shift_ins && MY_IDX > pos_ext)
        begin
            data_next = prev_data;
        end
        else if (ctrl.shift_ins && MY_IDX == pos_ext)
        begin
            data_next = ctrl.value;
        end
        else if (ctrl.shift_del && MY_IDX >= pos_ext)
        begin
            // last cell takes junk from beyond the list, never read
            data_next = next_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule : ili_cell

`default_nettype wire

// ===== rtl/indexed_list_insert_delete.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_delete
// Ordered list of 32-bit values in a row of entry cells, with insert, delete
// and read at an index.
// ----------------------------------------------------------------------------
//  channel  | signals                     | direction
//  ---------+-----------------------------+----------
//  request  | req_valid, req_stall, req   | in
//  response | rsp_valid, rsp_stall, rsp   | out
//  config   | cfg_we, cfg_wdata           | in
//
//  one request per cycle unless req_stall is high: all cells shift in the
//  same cycle, so the cell row and the single length counter step per request.
//  response appears in the cycle after acceptance, from an output register.
//  req_stall rises only while a response waits and rsp_stall is high.
//  rst_n clears the length and the response valid, sets the capacity to 16;
//  entries hold no reset and are read only after they were written.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_insert_delete
    import ili_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire req_t       req,
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    output rsp_t            rsp,
    input  wire logic       cfg_we,
    input  wire logic [4:0] cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_ENTRIES);

    logic [4:0]       capacity_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    logic             accept;
    logic [IDX_W-1:0] count_ext;
    logic [IDX_W-1:0] pos_ext;
    logic [IDX_W-1:0] cap_eff;
    logic             ins_ok;
    logic             del_ok;
    logic             rd_ok;
    logic [31:0]      rd_sel;
    cell_ctrl_t       ctrl;
    logic [31:0]      cell_data [MAX_ENTRIES];

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign count_ext = IDX_W'(count_reg);
    assign pos_ext   = IDX_W'(req.position);
    assign cap_eff   = (IDX_W'(capacity_reg) > MAX_IDX) ? MAX_IDX : IDX_W'(capacity_reg);

    assign ins_ok = (req.mode == MODE_INSERT) && (count_ext < cap_eff)
                    && (pos_ext <= count_ext) && (count_ext < MAX_IDX);
    assign del_ok = (req.mode == MODE_DELETE) && (pos_ext < count_ext);
    assign rd_ok  = (req.mode == MODE_READ) && (pos_ext < count_ext);

    assign ctrl.shift_ins = accept && ins_ok;
    assign ctrl.shift_del = accept && del_ok;
    assign ctrl.position  = req.position;
    assign ctrl.value     = req.value_in;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            logic [31:0] prev_d;
            logic [31:0] next_d;
            if (gi == 0)
            begin : g_first
                assign prev_d = req.value_in;
            end
            else
            begin : g_mid_prev
                assign prev_d = cell_data[gi-1];
            end
            if (gi == MAX_ENTRIES - 1)
            begin : g_last
                assign next_d = '0;
            end
            else
            begin : g_mid_next
                assign next_d = cell_data[gi+1];
            end
            ili_cell #(
                .INDEX(gi)
            ) u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .prev_data(prev_d),
                .next_data(next_d),
                .data     (cell_data[gi])
            );
        end
    endgenerate

    // select the addressed cell for a read
    always_comb
    begin
        rd_sel = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (IDX_W'(i) == pos_ext)
            begin
                rd_sel = cell_data[i];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        priority if (ins_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (del_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= 5'd16;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg.ok          <= ins_ok || del_ok || rd_ok;
            rsp_reg.count_after <= 5'(count_next);
            rsp_reg.read_value  <= rd_ok ? rd_sel : '0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule : indexed_list_insert_delete

`default_nettype wire

// ===== test/tb_indexed_list_insert_delete.sv =====
// ----------------------------------------------------------------------------
// tb_indexed_list_insert_delete
// Drives insert, delete and read requests into the indexed list and checks
// every response against a behavioral copy of the list kept in a scoreboard.
// The capacity register is stepped through several values, zero and values
// above the built depth among them, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_indexed_list_insert_delete;
    import ili_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         LIST_DEPTH   = 16;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         PHASE_ITEMS  = 72;
    localparam int         QUIET_PHASE  = 5;
    localparam int         PAUSE_PHASE  = 3;

    class list_scoreboard;
        logic signed [31:0] cells [LIST_DEPTH];
        int unsigned        length;
        logic [4:0]         capacity;
        rsp_t               pending [$];
        int unsigned        errors;

        function new();
            foreach (cells[i]) cells[i] = '0;
            length   = 0;
            capacity = 5'd16;
            errors   = 0;
        endfunction

        // work out the response of an accepted request and update the list
        function void note_request(req_t r);
            rsp_t        exp;
            int unsigned cap;
            int unsigned i;
            exp = '0;
            cap = (capacity > LIST_DEPTH) ? LIST_DEPTH : int'(capacity);
            case (r.mode)
                MODE_INSERT:
                    if (length < cap && r.position <= length)
                    begin
                        for (i = length; i > r.position; i--)
                            cells[i] = cells[i-1];
                        cells[r.position] = r.value_in;
                        length++;
                        exp.ok = 1'b1;
                    end
                MODE_DELETE:
                    if (r.position < length)
                    begin
                        for (i = r.position; i + 1 < length; i++)
                            cells[i] = cells[i+1];
                        length--;
                        exp.ok = 1'b1;
                    end
                MODE_READ:
                    if (r.position < length)
                    begin
                        exp.read_value = cells[r.position];
                        exp.ok         = 1'b1;
                    end
                default: ;
            endcase
            exp.count_after = length[4:0];
            pending.push_back(exp);
        endfunction

        function void check_response(rsp_t got);
            rsp_t exp;
            if (pending.size() == 0)
            begin
                $error("response with no request outstanding");
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.ok !== exp.ok)
            begin
                $error("ok: expected %0d, got %0d", exp.ok, got.ok);
                errors++;
            end
            if (got.count_after !== exp.count_after)
            begin
                $error("count_after: expected %0d, got %0d",
                       exp.count_after, got.count_after);
                errors++;
            end
            if (got.read_value !== exp.read_value)
            begin
                $error("read_value: expected %0d, got %0d",
                       exp.read_value, got.read_value);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    req_t       req;
    logic       rsp_valid;
    logic       rsp_stall;
    rsp_t       rsp;
    logic       cfg_we;
    logic [4:0] cfg_wdata;

    list_scoreboard sb = new();
    int unsigned    accepted = 0;
    logic           idle_on  = 1'b1;

    indexed_list_insert_delete #(
        .MAX_ENTRIES(LIST_DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(negedge clk)
    begin
        rsp_stall <= idle_on && ($urandom_range(99) < 10);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.capacity = cfg_wdata;
            if (req_valid && !req_stall)
            begin
                sb.note_request(req);
                accepted++;
            end
            if (rsp_valid && !rsp_stall)
                sb.check_response(rsp);
        end
    end

    // returns at the falling edge after the request was taken, valid still high
    task automatic send_request(input logic [1:0] mode, input logic [4:0] pos,
                                input logic [31:0] val);
        req_t        item;
        int unsigned seen;
        item.mode     = mode;
        item.position = pos;
        item.value_in = val;
        if (idle_on)
        begin
            while ($urandom_range(99) < 10)
            begin
                req_valid <= 1'b0;
                @(negedge clk);
            end
        end
        req_valid <= 1'b1;
        req       <= item;
        seen = accepted;
        do
            @(negedge clk);
        while (accepted == seen);
    endtask

    task automatic wait_for_drain();
        req_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [4:0] cap);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly in-range positions for the current length, some anywhere
    function automatic req_t random_request(int unsigned len);
        req_t        r;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45)
            r.mode = MODE_INSERT;
        else if (pick < 75)
            r.mode = MODE_DELETE;
        else if (pick < 95)
            r.mode = MODE_READ;
        else
            r.mode = MODE_UNUSED;
        if ($urandom_range(99) < 15)
            r.position = 5'($urandom_range(31));
        else if (r.mode == MODE_INSERT)
            r.position = 5'($urandom_range(len));
        else if (len == 0)
            r.position = 5'd0;
        else
            r.position = 5'($urandom_range(len - 1));
        pick = $urandom_range(9);
        if (pick == 0)
            r.value_in = 32'h8000_0000;
        else if (pick == 1)
            r.value_in = 32'h7fff_ffff;
        else
            r.value_in = $urandom;
        return r;
    endfunction

    initial
    begin
        logic [4:0] cap_plan [8];
        req_t       r;
        int         p;
        int         k;

        cap_plan = '{5'd1, 5'd0, 5'd31, 5'd9, 5'd17, 5'd16, 5'd3, 5'd16};
        cap_plan[3] = 5'($urandom_range(1, 16));

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        rsp_stall = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty list, extremes, bad indexes, unused mode
        send_request(MODE_READ,   5'd0,  32'd0);
        send_request(MODE_DELETE, 5'd0,  32'd0);
        send_request(MODE_INSERT, 5'd1,  32'h1234_5678);
        send_request(MODE_INSERT, 5'd0,  32'h8000_0000);
        send_request(MODE_INSERT, 5'd1,  32'h7fff_ffff);
        send_request(MODE_INSERT, 5'd0,  32'hffff_ffff);
        send_request(MODE_INSERT, 5'd3,  32'h0000_0000);
        send_request(MODE_READ,   5'd0,  32'd0);
        send_request(MODE_READ,   5'd3,  32'hdead_beef);
        send_request(MODE_READ,   5'd4,  32'd0);
        send_request(MODE_DELETE, 5'd31, 32'd0);
        send_request(MODE_READ,   5'd31, 32'd0);
        send_request(MODE_UNUSED, 5'd0,  32'hffff_ffff);
        send_request(MODE_INSERT, 5'd31, 32'h0f0f_0f0f);
        send_request(MODE_DELETE, 5'd1,  32'd0);
        send_request(MODE_DELETE, 5'd2,  32'd0);
        send_request(MODE_READ,   5'd1,  32'd0);
        send_request(MODE_INSERT, 5'd2,  32'h5555_5555);
        send_request(MODE_INSERT, 5'd1,  32'haaaa_aaaa);
        send_request(MODE_READ,   5'd2,  32'd0);

        for (p = 0; p < 8; p++)
        begin
            wait_for_drain();
            write_capacity(cap_plan[p]);
            idle_on = (p != QUIET_PHASE);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == PAUSE_PHASE && k == PHASE_ITEMS / 2)
                    wait_for_drain();
                r = random_request(sb.length);
                send_request(r.mode, r.position, r.value_in);
            end
        end

        wait_for_drain();
        repeat (5) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
